/* design/da2d_pkg.sv */
// Package for the two-dimensional difference-array engine.
// Holds field widths, command and register codes, the sequencer states, the
// accumulator control struct shared with da2d_acc, and the pend_t struct.
package da2d_pkg;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int COORD_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;
  localparam logic [CFG_W-1:0]     REG_RESET_VALUE = 7'd64;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 3'd0,
    CMD_CONVERT = 3'd1,
    CMD_ADD     = 3'd2,
    CMD_MERGE   = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr;
    logic add;
    logic neg;
  } acc_ctrl_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } pend_t;

endpackage

/* design/da2d_if.sv */
// Handshake interfaces for the command and result channels.
// Depends on da2d_pkg for the field widths.
interface da2d_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [da2d_pkg::CMD_W-1:0]         command;
  logic [da2d_pkg::COORD_W-1:0]       row_first;
  logic [da2d_pkg::COORD_W-1:0]       col_first;
  logic [da2d_pkg::COORD_W-1:0]       row_last;
  logic [da2d_pkg::COORD_W-1:0]       col_last;
  logic signed [da2d_pkg::DATA_W-1:0] amount;

  modport source (
    output valid, command, row_first, col_first, row_last, col_last, amount,
    input  ready
  );
  modport sink (
    input  valid, command, row_first, col_first, row_last, col_last, amount,
    output ready
  );
endinterface

interface da2d_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [da2d_pkg::DATA_W-1:0] cell_value;
  logic                               status;

  modport source (output valid, cell_value, status, input ready);
  modport sink (input valid, cell_value, status, output ready);
endinterface

/* design/da2d_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module da2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/da2d_acc.sv */
// Shared add/subtract accumulator: sums stencil terms or adds a bias to a cell.
// Depends on da2d_pkg for the control struct and data width.
module da2d_acc (
  input  logic                          clk_i,
  input  da2d_pkg::acc_ctrl_t           ctrl_i,
  input  logic [da2d_pkg::DATA_W-1:0]   operand_i,
  input  logic [da2d_pkg::DATA_W-1:0]   bias_i,
  output logic [da2d_pkg::DATA_W-1:0]   sum_o
);

  logic [da2d_pkg::DATA_W-1:0] acc_q;
  logic [da2d_pkg::DATA_W-1:0] acc_d;
  logic [da2d_pkg::DATA_W-1:0] contrib;

  always_comb begin
    if (!ctrl_i.add) begin
      contrib = '0;
    end else if (ctrl_i.neg) begin
      contrib = da2d_pkg::DATA_W'(0) - operand_i;
    end else begin
      contrib = operand_i;
    end
    acc_d = acc_q + contrib;
  end

  assign sum_o = acc_d + bias_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

/* design/da2d_seq.sv */
// Sequencer: configuration registers, command decode, grid walk, corner
// updates, clearing sweep and the result register. Depends on da2d_pkg and
// the channel interfaces; drives the grid RAM and the accumulator.
module da2d_seq #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [da2d_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [da2d_pkg::CFG_W-1:0]          cfg_wdata_i,
  da2d_cmd_if.sink                            cmd_i,
  da2d_res_if.source                          res_o,
  output logic                                ram_we_o,
  output logic [AW-1:0]                       ram_waddr_o,
  output logic [da2d_pkg::DATA_W-1:0]         ram_wdata_o,
  output logic [AW-1:0]                       ram_raddr_o,
  input  logic [da2d_pkg::DATA_W-1:0]         ram_rdata_i,
  output da2d_pkg::acc_ctrl_t                 acc_ctrl_o,
  output logic [da2d_pkg::DATA_W-1:0]         acc_bias_o,
  input  logic [da2d_pkg::DATA_W-1:0]         acc_sum_i
);

  localparam int RCW = ($clog2(MAX_ROWS + 2) > 8) ? $clog2(MAX_ROWS + 2) : 8;
  localparam int CCW = ($clog2(MAX_COLS + 2) > 8) ? $clog2(MAX_COLS + 2) : 8;

  function automatic logic [AW-1:0] cell_addr(input logic [RCW-1:0] r,
                                              input logic [CCW-1:0] c);
    logic [AW-1:0] rr;
    logic [AW-1:0] cc;
    rr = AW'(r - 1'b1);
    cc = AW'(c - 1'b1);
    return rr * AW'(MAX_COLS) + cc;
  endfunction

  da2d_pkg::state_e              state_q, state_d;
  da2d_pkg::cmd_e                op_q, op_d;
  logic [AW-1:0]                 clr_q, clr_d;
  logic [da2d_pkg::CFG_W-1:0]    rows_q, cols_q;
  logic [1:0]                    term_q, term_d;
  logic [1:0]                    corner_q, corner_d;
  da2d_pkg::pend_t               pend_q, pend_d;
  logic [RCW-1:0]                row_q, row_d, r1_q, r1_d, r2p_q, r2p_d;
  logic [CCW-1:0]                col_q, col_d, c1_q, c1_d, c2p_q, c2p_d;
  logic [da2d_pkg::DATA_W-1:0]   amount_q, amount_d;
  logic [da2d_pkg::DATA_W-1:0]   res_value_q, res_value_d;
  logic                          res_status_q, res_status_d;

  logic [RCW-1:0] rows_ext, nr, in_r1, in_r2, tr, cr, rd_r, wr_r;
  logic [CCW-1:0] cols_ext, nc, in_c1, in_c2, tc, cc, rd_c, wr_c;
  logic           cell_ok, rect_ok, t_valid, t_neg, cneg, corner_use;
  logic           is_conv, walk_last;

  always_comb begin
    rows_ext = RCW'(rows_q);
    cols_ext = CCW'(cols_q);
    nr = (rows_ext > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : rows_ext;
    nc = (cols_ext > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : cols_ext;

    in_r1 = RCW'(cmd_i.row_first);
    in_r2 = RCW'(cmd_i.row_last);
    in_c1 = CCW'(cmd_i.col_first);
    in_c2 = CCW'(cmd_i.col_last);
    cell_ok = (in_r1 != '0) && (in_r1 <= RCW'(MAX_ROWS))
           && (in_c1 != '0) && (in_c1 <= CCW'(MAX_COLS));
    rect_ok = cell_ok && (in_r2 != '0) && (in_r2 <= RCW'(MAX_ROWS))
           && (in_c2 != '0) && (in_c2 <= CCW'(MAX_COLS))
           && (in_r1 <= in_r2) && (in_c1 <= in_c2);

    is_conv = (op_q == da2d_pkg::CMD_CONVERT);
    tr = term_q[0] ? row_q - 1'b1 : row_q;
    tc = term_q[1] ? col_q - 1'b1 : col_q;
    t_valid = (tr != '0) && (tc != '0);
    t_neg = is_conv ? (term_q[0] ^ term_q[1]) : (term_q == 2'd3);
    walk_last = is_conv ? ((row_q == RCW'(1)) && (col_q == CCW'(1)))
                        : ((row_q == nr) && (col_q == nc));

    case (corner_q)
      2'd0: begin
        cr = r1_q;
        cc = c1_q;
        cneg = 1'b0;
      end
      2'd1: begin
        cr = r1_q;
        cc = c2p_q;
        cneg = 1'b1;
      end
      2'd2: begin
        cr = r2p_q;
        cc = c1_q;
        cneg = 1'b1;
      end
      default: begin
        cr = r2p_q;
        cc = c2p_q;
        cneg = 1'b0;
      end
    endcase
    corner_use = (cr <= nr) && (cc <= nc);
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    clr_d        = clr_q;
    term_d       = term_q;
    corner_d     = corner_q;
    pend_d       = '0;
    row_d        = row_q;
    col_d        = col_q;
    r1_d         = r1_q;
    r2p_d        = r2p_q;
    c1_d         = c1_q;
    c2p_d        = c2p_q;
    amount_d     = amount_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    ram_we_o     = 1'b0;
    ram_wdata_o  = acc_sum_i;
    wr_r         = row_q;
    wr_c         = col_q;
    rd_r         = tr;
    rd_c         = tc;
    acc_ctrl_o   = '0;
    acc_bias_o   = '0;

    case (state_q)
      da2d_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = da2d_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      da2d_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          op_d         = da2d_pkg::cmd_e'(cmd_i.command);
          res_value_d  = '0;
          res_status_d = da2d_pkg::STATUS_DONE;
          state_d      = da2d_pkg::ST_DONE;
          term_d       = '0;
          corner_d     = '0;
          case (cmd_i.command)
            da2d_pkg::CMD_LOAD: begin
              if (cell_ok) begin
                ram_we_o    = 1'b1;
                wr_r        = in_r1;
                wr_c        = in_c1;
                ram_wdata_o = cmd_i.amount;
              end else begin
                res_status_d = da2d_pkg::STATUS_IGNORED;
              end
            end
            da2d_pkg::CMD_READ: begin
              rd_r = in_r1;
              rd_c = in_c1;
              if (cell_ok) begin
                state_d = da2d_pkg::ST_LAST;
              end else begin
                res_status_d = da2d_pkg::STATUS_IGNORED;
              end
            end
            da2d_pkg::CMD_ADD: begin
              if (rect_ok) begin
                r1_d     = in_r1;
                c1_d     = in_c1;
                r2p_d    = in_r2 + 1'b1;
                c2p_d    = in_c2 + 1'b1;
                amount_d = cmd_i.amount;
                state_d  = da2d_pkg::ST_READ;
              end else begin
                res_status_d = da2d_pkg::STATUS_IGNORED;
              end
            end
            da2d_pkg::CMD_CONVERT: begin
              if ((nr != '0) && (nc != '0)) begin
                row_d   = nr;
                col_d   = nc;
                state_d = da2d_pkg::ST_READ;
              end
            end
            da2d_pkg::CMD_MERGE: begin
              if ((nr != '0) && (nc != '0)) begin
                row_d   = RCW'(1);
                col_d   = CCW'(1);
                state_d = da2d_pkg::ST_READ;
              end
            end
            default: begin
              res_status_d = da2d_pkg::STATUS_IGNORED;
            end
          endcase
        end
      end
      da2d_pkg::ST_READ: begin
        if (op_q == da2d_pkg::CMD_ADD) begin
          rd_r = cr;
          rd_c = cc;
          if (corner_use) begin
            acc_ctrl_o.clr = 1'b1;
            pend_d         = '{valid: 1'b1, neg: 1'b0};
            state_d        = da2d_pkg::ST_LAST;
          end else if (corner_q == 2'd3) begin
            state_d = da2d_pkg::ST_DONE;
          end else begin
            corner_d = corner_q + 1'b1;
          end
        end else begin
          acc_ctrl_o.clr = (term_q == 2'd0);
          acc_ctrl_o.add = pend_q.valid;
          acc_ctrl_o.neg = pend_q.neg;
          pend_d         = '{valid: t_valid, neg: t_neg};
          if (term_q == 2'd3) begin
            state_d = da2d_pkg::ST_LAST;
          end else begin
            term_d = term_q + 1'b1;
          end
        end
      end
      da2d_pkg::ST_LAST: begin
        acc_ctrl_o.add = pend_q.valid;
        acc_ctrl_o.neg = pend_q.neg;
        case (op_q)
          da2d_pkg::CMD_READ: begin
            res_value_d = ram_rdata_i;
            state_d     = da2d_pkg::ST_DONE;
          end
          da2d_pkg::CMD_ADD: begin
            ram_we_o   = 1'b1;
            wr_r       = cr;
            wr_c       = cc;
            acc_bias_o = cneg ? da2d_pkg::DATA_W'(0) - amount_q : amount_q;
            if (corner_q == 2'd3) begin
              state_d = da2d_pkg::ST_DONE;
            end else begin
              corner_d = corner_q + 1'b1;
              state_d  = da2d_pkg::ST_READ;
            end
          end
          default: begin
            ram_we_o = 1'b1;
            term_d   = '0;
            if (walk_last) begin
              state_d = da2d_pkg::ST_DONE;
            end else begin
              state_d = da2d_pkg::ST_READ;
              if (is_conv) begin
                if (col_q == CCW'(1)) begin
                  col_d = nc;
                  row_d = row_q - 1'b1;
                end else begin
                  col_d = col_q - 1'b1;
                end
              end else begin
                if (col_q == nc) begin
                  col_d = CCW'(1);
                  row_d = row_q + 1'b1;
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            end
          end
        endcase
      end
      da2d_pkg::ST_DONE: begin
        if (res_o.ready) begin
          state_d = da2d_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = da2d_pkg::ST_IDLE;
      end
    endcase
  end

  assign ram_waddr_o = (state_q == da2d_pkg::ST_CLEAR) ? clr_q : cell_addr(wr_r, wr_c);
  assign ram_raddr_o = cell_addr(rd_r, rd_c);

  assign cmd_i.ready      = (state_q == da2d_pkg::ST_IDLE);
  assign res_o.valid      = (state_q == da2d_pkg::ST_DONE);
  assign res_o.cell_value = res_value_q;
  assign res_o.status     = res_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= da2d_pkg::ST_CLEAR;
      op_q     <= da2d_pkg::CMD_LOAD;
      clr_q    <= '0;
      term_q   <= '0;
      corner_q <= '0;
      pend_q   <= '0;
      rows_q   <= da2d_pkg::REG_RESET_VALUE;
      cols_q   <= da2d_pkg::REG_RESET_VALUE;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      clr_q    <= clr_d;
      term_q   <= term_d;
      corner_q <= corner_d;
      pend_q   <= pend_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          da2d_pkg::REG_ROWS_IN_USE: rows_q <= cfg_wdata_i;
          da2d_pkg::REG_COLS_IN_USE: cols_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    col_q        <= col_d;
    r1_q         <= r1_d;
    r2p_q        <= r2p_d;
    c1_q         <= c1_d;
    c2p_q        <= c2p_d;
    amount_q     <= amount_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

endmodule

/* design/difference_array_2d.sv */
// Top level of the two-dimensional difference-array engine.
// Depends on da2d_pkg, the channel interfaces, da2d_seq, da2d_ram and da2d_acc.
//
// Commands arrive on cmd_i (load, convert, range add, merge, read) and each
// transaction produces exactly one result transaction on res_o, carrying the
// cell value for a read (zero otherwise) and a status bit that is set when the
// command was ignored. The configuration port sets the rows and columns in use;
// the user must write it only while the block is idle, which is not enforced.
// After reset the grid RAM is cleared by a sweep over all MAX_ROWS*MAX_COLS cells
// (4096 by default) during which cmd_i.ready stays low.
// One command is processed at a time; ready is high only when idle. A load or a
// rejected command goes straight to its result; a read registers the cell from
// the grid RAM before presenting it; a range add reads and writes back each
// corner kept and skips each corner dropped; convert and merge visit every cell
// in use, reading the single read port of the grid RAM once per stencil term,
// followed by a write-back through the shared accumulator.
// A result is held on res_o until the receiver takes it; the next command can be
// accepted from the cycle after that on.
module difference_array_2d #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [da2d_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [da2d_pkg::CFG_W-1:0]     cfg_wdata_i,
  da2d_cmd_if.sink                       cmd_i,
  da2d_res_if.source                     res_o
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  logic [da2d_pkg::DATA_W-1:0] ram_wdata;
  logic [da2d_pkg::DATA_W-1:0] ram_rdata;
  da2d_pkg::acc_ctrl_t         acc_ctrl;
  logic [da2d_pkg::DATA_W-1:0] acc_bias;
  logic [da2d_pkg::DATA_W-1:0] acc_sum;

  da2d_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .acc_ctrl_o  (acc_ctrl),
    .acc_bias_o  (acc_bias),
    .acc_sum_i   (acc_sum)
  );

  da2d_ram #(
    .WIDTH (da2d_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  da2d_acc u_acc (
    .clk_i     (clk_i),
    .ctrl_i    (acc_ctrl),
    .operand_i (ram_rdata),
    .bias_i    (acc_bias),
    .sum_o     (acc_sum)
  );

endmodule

/* tb/sv/tb_top.sv */
// Testbench for difference_array_2d: directed and random command streams with random
// stalls on both channels, each result checked against an in-bench grid model.
// Depends on da2d_pkg, the channel interfaces and the difference_array_2d RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import da2d_pkg::*;

  localparam int CLK_PERIOD       = 20;
  localparam int GRID_ROWS        = 64;
  localparam int GRID_COLS        = 64;
  localparam int ITEM_TARGET      = 450;
  localparam int QUIET_TAIL_ITEMS = 60;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 40;
  localparam int WATCHDOG_LIMIT   = 100000;

  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] row_last;
    logic [COORD_W-1:0] col_last;
    logic [DATA_W-1:0]  amount;
  } grid_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] cell_value;
    logic              status;
  } grid_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  da2d_cmd_if cmd_bus ();
  da2d_res_if res_bus ();

  difference_array_2d uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_bus),
    .res_o       (res_bus)
  );

  logic [DATA_W-1:0] grid_model [1:GRID_ROWS][1:GRID_COLS];
  logic [CFG_W-1:0]  rows_cfg = REG_RESET_VALUE;
  logic [CFG_W-1:0]  cols_cfg = REG_RESET_VALUE;

  grid_result_t expected_results [$];
  grid_result_t want;

  bit idle_enable = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int sweeps_sent = 0;
  int settings_used = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [DATA_W-1:0] cell_at(int r, int c);
    if (r < 1 || c < 1 || r > GRID_ROWS || c > GRID_COLS) begin
      return '0;
    end
    return grid_model[r][c];
  endfunction

  function automatic int clip_span(logic [CFG_W-1:0] v, int top);
    return (v > top) ? top : int'(v);
  endfunction

  function automatic bit coord_ok(logic [COORD_W-1:0] v, int top);
    return v >= 1 && v <= top;
  endfunction

  function automatic void corner_add(int r, int c, logic [DATA_W-1:0] k, int nr, int nc);
    if (r <= nr && c <= nc) begin
      grid_model[r][c] = grid_model[r][c] + k;
    end
  endfunction

  function automatic grid_result_t predict_command(grid_cmd_t cmd);
    grid_result_t res;
    int nr;
    int nc;
    int r1;
    int c1;
    int r2;
    int c2;
    res.cell_value = '0;
    res.status = STATUS_DONE;
    nr = clip_span(rows_cfg, GRID_ROWS);
    nc = clip_span(cols_cfg, GRID_COLS);
    r1 = cmd.row_first;
    c1 = cmd.col_first;
    r2 = cmd.row_last;
    c2 = cmd.col_last;
    case (cmd.command)
      CMD_LOAD: begin
        if (coord_ok(cmd.row_first, GRID_ROWS) && coord_ok(cmd.col_first, GRID_COLS)) begin
          grid_model[r1][c1] = cmd.amount;
        end else begin
          res.status = STATUS_IGNORED;
        end
      end
      CMD_CONVERT: begin
        for (int i = nr; i >= 1; i--) begin
          for (int j = nc; j >= 1; j--) begin
            grid_model[i][j] = grid_model[i][j] - cell_at(i - 1, j) - cell_at(i, j - 1)
                               + cell_at(i - 1, j - 1);
          end
        end
      end
      CMD_ADD: begin
        if (!coord_ok(cmd.row_first, GRID_ROWS) || !coord_ok(cmd.row_last, GRID_ROWS) ||
            !coord_ok(cmd.col_first, GRID_COLS) || !coord_ok(cmd.col_last, GRID_COLS) ||
            r1 > r2 || c1 > c2) begin
          res.status = STATUS_IGNORED;
        end else begin
          corner_add(r1, c1, cmd.amount, nr, nc);
          corner_add(r1, c2 + 1, -cmd.amount, nr, nc);
          corner_add(r2 + 1, c1, -cmd.amount, nr, nc);
          corner_add(r2 + 1, c2 + 1, cmd.amount, nr, nc);
        end
      end
      CMD_MERGE: begin
        for (int i = 1; i <= nr; i++) begin
          for (int j = 1; j <= nc; j++) begin
            grid_model[i][j] = grid_model[i][j] + cell_at(i - 1, j) + cell_at(i, j - 1)
                               - cell_at(i - 1, j - 1);
          end
        end
      end
      CMD_READ: begin
        if (coord_ok(cmd.row_first, GRID_ROWS) && coord_ok(cmd.col_first, GRID_COLS)) begin
          res.cell_value = grid_model[r1][c1];
        end else begin
          res.status = STATUS_IGNORED;
        end
      end
      default: begin
        res.status = STATUS_IGNORED;
      end
    endcase
    return res;
  endfunction

  function automatic grid_cmd_t make_cmd(logic [CMD_W-1:0] code, int r1, int c1, int r2,
                                         int c2, logic [DATA_W-1:0] amt);
    grid_cmd_t cmd;
    cmd.command   = code;
    cmd.row_first = COORD_W'(r1);
    cmd.col_first = COORD_W'(c1);
    cmd.row_last  = COORD_W'(r2);
    cmd.col_last  = COORD_W'(c2);
    cmd.amount    = amt;
    return cmd;
  endfunction

  function automatic logic [DATA_W-1:0] random_amount();
    logic [DATA_W-1:0] corners [4];
    corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(0, 3))
      0: return DATA_W'($urandom_range(0, 31)) - 32'd16;
      1: return corners[$urandom_range(0, 3)];
      default: return $urandom;
    endcase
  endfunction

  function automatic int area_size(logic [CFG_W-1:0] v, int top);
    if (v == 0) begin
      return 1;
    end
    return (v > top) ? top : int'(v);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_command(grid_cmd_t cmd);
    int gap;
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      cmd_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_bus.command   = cmd.command;
    cmd_bus.row_first = cmd.row_first;
    cmd_bus.col_first = cmd.col_first;
    cmd_bus.row_last  = cmd.row_last;
    cmd_bus.col_last  = cmd.col_last;
    cmd_bus.amount    = cmd.amount;
    cmd_bus.valid     = 1'b1;
    do @(posedge clk_i); while (!cmd_bus.ready);
    expected_results.insert(expected_results.size(), predict_command(cmd));
    items_sent++;
    if (cmd.command == CMD_CONVERT || cmd.command == CMD_MERGE) begin
      sweeps_sent++;
    end
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    wait_until_drained();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == REG_ROWS_IN_USE) begin
      rows_cfg = value;
    end else if (idx == REG_COLS_IN_USE) begin
      cols_cfg = value;
    end
  endtask

  task automatic send_noise();
    int r1;
    int r2;
    case ($urandom_range(0, 7))
      0: begin
        send_command(make_cmd(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 127),
                              $urandom_range(0, 127), $urandom_range(0, 127),
                              $urandom_range(0, 127), $urandom));
      end
      1: begin
        r1 = $urandom_range(1, GRID_ROWS - 1);
        r2 = $urandom_range(r1 + 1, GRID_ROWS);
        if ($urandom_range(0, 1) == 0) begin
          send_command(make_cmd(CMD_ADD, r2, 1, r1, GRID_COLS, random_amount()));
        end else begin
          send_command(make_cmd(CMD_ADD, 1, r2, GRID_ROWS, r1, random_amount()));
        end
      end
      default: begin
      end
    endcase
  endtask

  // Load, convert, add rectangles, merge and read back, mostly within the area in use, with noise commands mixed in.
  task automatic run_grid_sequence();
    int nr;
    int nc;
    int r1;
    int c1;
    int r2;
    int c2;
    nr = area_size(rows_cfg, GRID_ROWS);
    nc = area_size(cols_cfg, GRID_COLS);
    repeat ($urandom_range(1, 4)) begin
      send_command(make_cmd(CMD_LOAD, $urandom_range(1, nr), $urandom_range(1, nc), 0, 0,
                            random_amount()));
      send_noise();
    end
    send_command(make_cmd(CMD_CONVERT, 0, 0, 0, 0, $urandom));
    repeat ($urandom_range(2, 5)) begin
      r1 = $urandom_range(1, nr);
      c1 = $urandom_range(1, nc);
      r2 = ($urandom_range(0, 7) == 0) ? $urandom_range(r1, GRID_ROWS) : $urandom_range(r1, nr);
      c2 = ($urandom_range(0, 7) == 0) ? $urandom_range(c1, GRID_COLS) : $urandom_range(c1, nc);
      send_command(make_cmd(CMD_ADD, r1, c1, r2, c2, random_amount()));
      send_noise();
    end
    send_command(make_cmd(CMD_MERGE, $urandom_range(0, 127), 0, 0, 0, 0));
    repeat ($urandom_range(2, 5)) begin
      if ($urandom_range(0, 5) == 0) begin
        send_command(make_cmd(CMD_READ, $urandom_range(1, GRID_ROWS),
                              $urandom_range(1, GRID_COLS), 0, 0, $urandom));
      end else begin
        send_command(make_cmd(CMD_READ, $urandom_range(1, nr), $urandom_range(1, nc),
                              $urandom_range(0, 127), $urandom_range(0, 127), $urandom));
      end
    end
  endtask

  task automatic test_cell_access();
    send_command(make_cmd(CMD_READ, 1, 1, 0, 0, 0));
    send_command(make_cmd(CMD_LOAD, 1, 1, 0, 0, 32'h7FFF_FFFF));
    send_command(make_cmd(CMD_LOAD, GRID_ROWS, GRID_COLS, 127, 127, 32'h8000_0000));
    send_command(make_cmd(CMD_LOAD, 1, GRID_COLS, 0, 0, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_READ, GRID_ROWS, GRID_COLS, 0, 0, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_LOAD, 0, 5, 0, 0, 32'h1234_5678));
    send_command(make_cmd(CMD_LOAD, 5, 127, 0, 0, 32'h1234_5678));
    send_command(make_cmd(CMD_READ, 127, 1, 0, 0, 0));
  endtask

  task automatic test_bad_commands();
    send_command(make_cmd(CMD_UNUSED_5, 1, 1, 2, 2, 32'h0000_0001));
    send_command(make_cmd(CMD_UNUSED_6, 127, 127, 127, 127, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_UNUSED_7, 3, 3, 3, 3, 32'h5555_AAAA));
    send_command(make_cmd(CMD_ADD, 9, 2, 8, 4, 32'h0000_0007));
    send_command(make_cmd(CMD_ADD, 2, 9, 4, 8, 32'h0000_0007));
    send_command(make_cmd(CMD_ADD, 1, 1, 0, 127, 32'h0000_0007));
  endtask

  task automatic test_full_grid();
    send_command(make_cmd(CMD_CONVERT, 0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_ADD, 1, 1, GRID_ROWS, GRID_COLS, 32'h0000_0005));
    send_command(make_cmd(CMD_ADD, 2, 3, 5, 7, 32'h8000_0001));
    send_command(make_cmd(CMD_MERGE, 0, 0, 0, 0, 0));
    wait_until_drained();
    send_command(make_cmd(CMD_READ, 1, 1, 0, 0, 0));
    send_command(make_cmd(CMD_READ, 3, 4, 0, 0, 0));
  endtask

  task automatic test_register_limits();
    write_register(REG_ROWS_IN_USE, 7'd0);
    write_register(REG_COLS_IN_USE, 7'd0);
    send_command(make_cmd(CMD_CONVERT, 0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_ADD, 1, 1, 2, 2, 32'h0000_0009));
    write_register(REG_ROWS_IN_USE, 7'd127);
    write_register(REG_COLS_IN_USE, 7'd2);
    write_register(REG_UNUSED_2, 7'd0);
    write_register(REG_UNUSED_3, 7'd127);
    send_command(make_cmd(CMD_CONVERT, 0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_READ, GRID_ROWS, 2, 0, 0, 0));
    write_register(REG_ROWS_IN_USE, 7'd1);
    write_register(REG_COLS_IN_USE, 7'd127);
    send_command(make_cmd(CMD_MERGE, 0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_READ, 1, GRID_COLS, 0, 0, 0));
    settings_used += 3;
  endtask

  task automatic test_random();
    int rows;
    int cols;
    int kind;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - QUIET_TAIL_ITEMS) begin
        idle_enable = 1'b0;
      end
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        rows = $urandom_range(60, 127);
        cols = $urandom_range(0, 4);
      end else if (kind == 1) begin
        rows = $urandom_range(0, 4);
        cols = $urandom_range(60, 127);
      end else if (kind == 2) begin
        rows = $urandom_range(0, 12);
        cols = $urandom_range(0, 12);
      end else begin
        rows = $urandom_range(1, 8);
        cols = $urandom_range(1, 8);
      end
      write_register(REG_ROWS_IN_USE, CFG_W'(rows));
      write_register(REG_COLS_IN_USE, CFG_W'(cols));
      settings_used++;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) begin
          wait_until_drained();
        end
        run_grid_sequence();
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      res_bus.ready = 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      res_bus.ready = 1'b0;
    end else begin
      res_bus.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (res_bus.valid && res_bus.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: value %h status %b",
                                  res_bus.cell_value, res_bus.status));
      end else begin
        want = expected_results.pop_front();
        if (res_bus.cell_value !== want.cell_value) begin
          report_mismatch($sformatf("cell_value got %h expected %h",
                                    res_bus.cell_value, want.cell_value));
        end
        if (res_bus.status !== want.status) begin
          report_mismatch($sformatf("status got %b expected %b", res_bus.status,
                                    want.status));
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("difference_array_2d test failed");
        $finish;
      end
    end
  end

  initial begin
    cmd_bus.valid     = 1'b0;
    cmd_bus.command   = '0;
    cmd_bus.row_first = '0;
    cmd_bus.col_first = '0;
    cmd_bus.row_last  = '0;
    cmd_bus.col_last  = '0;
    cmd_bus.amount    = '0;
    res_bus.ready     = 1'b0;
    for (int i = 1; i <= GRID_ROWS; i++) begin
      for (int j = 1; j <= GRID_COLS; j++) begin
        grid_model[i][j] = '0;
      end
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    settings_used = 1;

    test_cell_access();
    test_bad_commands();
    test_full_grid();
    test_register_limits();
    test_random();

    wait_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("Sent %0d commands including %0d convert/merge sweeps over %0d register settings.",
             items_sent, sweeps_sent, settings_used);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("difference_array_2d test passed");
    end else begin
      $display("difference_array_2d test failed");
    end
    $finish;
  end

endmodule
